[hw/rtl/ffa_pkg.sv]
// ---------------------------------------------------------------------------
// ffa_pkg: shared definitions for the first-fit block allocator
// Field widths, op codes and register map of the allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

    localparam int OP_W    = 3;
    localparam int SIZE_W  = 13;
    localparam int ADDR_W  = 12;
    localparam int CNT_W   = 13;
    localparam int SLACK_W = 5;
    localparam int BSU_W   = 11;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 3'd0,
        OP_FREE    = 3'd1,
        OP_REALLOC = 3'd2,
        OP_LARGEST = 3'd3,
        OP_INIT    = 3'd4
    } t_op;

    // word index of the pool size register
    localparam logic REG_POOL = 1'b0;

    localparam logic [SIZE_W-1:0] POOL_RESET = 13'd4096;

endpackage

`default_nettype wire

[hw/rtl/ffa_if.sv]
// ---------------------------------------------------------------------------
// ffa_if: request and response channels of the block allocator
// Valid/ready channels; an item moves when valid and ready are both high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ffa_req_if;
    logic                         valid;
    logic                         ready;
    logic [ffa_pkg::OP_W-1:0]     op;
    logic [ffa_pkg::SIZE_W-1:0]   size;
    logic [ffa_pkg::ADDR_W-1:0]   address;

    modport source (output valid, op, size, address, input ready);
    modport sink   (input valid, op, size, address, output ready);
endinterface

interface ffa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         status;
    logic [ffa_pkg::ADDR_W-1:0]   result_address;
    logic                         moved;
    logic [ffa_pkg::CNT_W-1:0]    copy_bytes;
    logic [ffa_pkg::CNT_W-1:0]    largest_free;
    logic [ffa_pkg::CNT_W-1:0]    free_bytes;
    logic [ffa_pkg::CNT_W-1:0]    requested_bytes;

    modport source (output valid, status, result_address, moved, copy_bytes,
                    largest_free, free_bytes, requested_bytes, input ready);
    modport sink   (input valid, status, result_address, moved, copy_bytes,
                    largest_free, free_bytes, requested_bytes, output ready);
endinterface

`default_nettype wire

[hw/rtl/first_fit_block_allocator.sv]
// ---------------------------------------------------------------------------
// first_fit_block_allocator: first-fit allocator over a pool of 8-byte units
// Header memory walked by a small sequencer, one header read per cycle.
// ---------------------------------------------------------------------------
// Operation: the sequencer walks the header chain through the single
// registered read port of the header memory. Free and realloc walk from
// unit 0 to the named block, then over the free run after it; alloc walks
// from the first-free hint until a block fits or the end sentinel is
// reached, and query walks from the hint to the sentinel. Reset and
// reinitialize write only the first header; there is no clearing pass.
// The request channel is ready only while the sequencer is idle; a
// finished result sits in an output register, so the next item may be
// taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator #(
    parameter int POOL_BYTES = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    ffa_req_if.sink                            i_req,
    ffa_rsp_if.source                          o_rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ffa_pkg::APB_AW-1:0]    paddr,
    input  wire logic [ffa_pkg::APB_DW-1:0]    pwdata,
    output logic      [ffa_pkg::APB_DW-1:0]    prdata,
    output logic                               pready
);

    localparam int MAX_UNITS = POOL_BYTES / 8;
    localparam int UW        = $clog2(MAX_UNITS);
    localparam int WW        = ((UW > 11) ? UW : 11) + 2;
    localparam int CW        = ffa_pkg::CNT_W;
    localparam int SW        = ffa_pkg::SLACK_W;
    localparam int BW        = ffa_pkg::BSU_W;
    localparam int AW        = ffa_pkg::ADDR_W;
    localparam logic [WW-1:0] MAXU = WW'(MAX_UNITS);

    typedef struct packed {
        logic [UW-1:0] nxt;
        logic [SW-1:0] slack;
        logic          used;
    } t_hdr;

    typedef enum logic [12:0] {
        ST_INIT     = 13'b0000000000001,
        ST_IDLE     = 13'b0000000000010,
        ST_FIND     = 13'b0000000000100,
        ST_FREE_HDR = 13'b0000000001000,
        ST_FREE_MRG = 13'b0000000010000,
        ST_RE_HDR   = 13'b0000000100000,
        ST_RE_NX    = 13'b0000001000000,
        ST_RE_MRG   = 13'b0000010000000,
        ST_AL_START = 13'b0000100000000,
        ST_AL_WALK  = 13'b0001000000000,
        ST_AL_MRG   = 13'b0010000000000,
        ST_WR_NN    = 13'b0100000000000,
        ST_DONE     = 13'b1000000000000
    } t_state;

    function automatic logic [WW-1:0] zx(input logic [UW-1:0] u);
        return {{(WW-UW){1'b0}}, u};
    endfunction

    function automatic logic [CW-1:0] u2b(input logic [WW-1:0] u);
        logic [WW+2:0] b;
        b = {u, 3'b000};
        return b[CW-1:0];
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [UW-1:0] u);
        logic [WW-1:0] p;
        logic [WW+2:0] b;
        p = zx(u) + WW'(1);
        b = {p, 3'b000};
        return b[AW-1:0];
    endfunction

    // header memory
    t_hdr r_mem [MAX_UNITS];
    t_hdr r_q;

    t_state                 r_state, n_state;
    logic [2:0]             r_op, n_op;
    logic [CW-1:0]          r_size, n_size;
    logic [BW-1:0]          r_bsu, n_bsu;
    logic [SW-1:0]          r_slack_new, n_slack_new;
    logic [WW-1:0]          r_t, n_t;
    logic [UW-1:0]          r_h, n_h;
    logic [UW-1:0]          r_node, n_node;
    logic [UW-1:0]          r_nx, n_nx;
    logic [UW-1:0]          r_nn, n_nn;
    logic [UW-1:0]          r_nn_next, n_nn_next;
    logic [WW-1:0]          r_capu, n_capu;
    logic [WW-1:0]          r_spare, n_spare;
    logic [CW-1:0]          r_old, n_old;
    logic                   r_shrink, n_shrink;
    logic                   r_first, n_first;
    logic                   r_move, n_move;
    logic                   r_moved, n_moved;
    logic                   r_from_op, n_from_op;
    logic                   r_status, n_status;
    logic [AW-1:0]          r_res_addr, n_res_addr;
    logic [WW-1:0]          r_best, n_best;
    logic [UW-1:0]          r_cur, n_cur;
    logic [UW-1:0]          r_last, n_last;
    logic [UW-1:0]          r_hint, n_hint;
    logic [CW-1:0]          r_free, n_free;
    logic [CW-1:0]          r_req, n_req;
    logic [CW-1:0]          r_pool, n_pool;

    logic                   r_o_valid, n_o_valid;
    logic                   r_o_status, n_o_status;
    logic [AW-1:0]          r_o_addr, n_o_addr;
    logic                   r_o_moved, n_o_moved;
    logic [CW-1:0]          r_o_copy, n_o_copy;
    logic [CW-1:0]          r_o_large, n_o_large;
    logic [CW-1:0]          r_o_free, n_o_free;
    logic [CW-1:0]          r_o_req, n_o_req;

    logic                   wr_en;
    logic [UW-1:0]          wr_idx;
    t_hdr                   wr_data;

    // decode of the header read last cycle (for r_cur)
    logic                   cur_end;
    logic [UW-1:0]          nx_dec;
    logic                   used_dec;
    logic [WW-1:0]          capu_dec;
    logic [WW-1:0]          bsu_w;
    logic [WW-1:0]          cap_h;
    logic [WW-1:0]          cap_n;
    logic [WW-1:0]          spare_h;
    logic [WW-1:0]          spare_n;
    logic [WW-1:0]          nn_hw;
    logic [WW-1:0]          nn_nw;
    logic [UW-1:0]          nn_h;
    logic [UW-1:0]          nn_n;
    logic [CW-1:0]          old_dec;

    // request decode
    logic [BW-1:0]          bsu_in;
    logic [13:0]            slk_tmp;
    logic [WW-1:0]          t_in;
    logic                   addr_bad;
    logic [WW-1:0]          units;
    logic                   apb_wr;

    assign cur_end  = (r_cur >= r_last);
    assign nx_dec   = cur_end ? r_last :
                      ((r_q.nxt <= r_cur || r_q.nxt > r_last) ? r_last : r_q.nxt);
    assign used_dec = cur_end | r_q.used;
    assign capu_dec = zx(nx_dec) - zx(r_cur);
    assign bsu_w    = {{(WW-BW){1'b0}}, r_bsu};
    assign cap_h    = zx(r_cur) - zx(r_h);
    assign cap_n    = zx(r_cur) - zx(r_node);
    assign spare_h  = cap_h - bsu_w;
    assign spare_n  = cap_n - bsu_w;
    assign nn_hw    = zx(r_h) + bsu_w;
    assign nn_nw    = zx(r_node) + bsu_w;
    assign nn_h     = nn_hw[UW-1:0];
    assign nn_n     = nn_nw[UW-1:0];
    assign old_dec  = u2b(capu_dec) - CW'(8) - {{(CW-SW){1'b0}}, r_q.slack};

    assign bsu_in   = {1'b0, i_req.size[12:3]} + BW'(1)
                    + {{(BW-1){1'b0}}, (i_req.size[2:0] != 3'd0) || (i_req.size == '0)};
    assign slk_tmp  = {bsu_in, 3'b000} - 14'd8 - {1'b0, i_req.size};
    assign t_in     = {{(WW-9){1'b0}}, i_req.address[11:3]} - WW'(1);
    assign addr_bad = (i_req.address[11:3] == '0) || (i_req.address[2:0] != 3'd0)
                    || (t_in >= zx(r_last));
    assign units    = ({{(WW-10){1'b0}}, r_pool[12:3]} > MAXU) ? MAXU
                    : {{(WW-10){1'b0}}, r_pool[12:3]};

    assign apb_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == ffa_pkg::REG_POOL)
                    ? {{(ffa_pkg::APB_DW-CW){1'b0}}, r_pool} : '0;

    assign i_req.ready           = (r_state == ST_IDLE);
    assign o_rsp.valid           = r_o_valid;
    assign o_rsp.status          = r_o_status;
    assign o_rsp.result_address  = r_o_addr;
    assign o_rsp.moved           = r_o_moved;
    assign o_rsp.copy_bytes      = r_o_copy;
    assign o_rsp.largest_free    = r_o_large;
    assign o_rsp.free_bytes      = r_o_free;
    assign o_rsp.requested_bytes = r_o_req;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_size      = r_size;
        n_bsu       = r_bsu;
        n_slack_new = r_slack_new;
        n_t         = r_t;
        n_h         = r_h;
        n_node      = r_node;
        n_nx        = r_nx;
        n_nn        = r_nn;
        n_nn_next   = r_nn_next;
        n_capu      = r_capu;
        n_spare     = r_spare;
        n_old       = r_old;
        n_shrink    = r_shrink;
        n_first     = r_first;
        n_move      = r_move;
        n_moved     = r_moved;
        n_from_op   = r_from_op;
        n_status    = r_status;
        n_res_addr  = r_res_addr;
        n_best      = r_best;
        n_cur       = r_cur;
        n_last      = r_last;
        n_hint      = r_hint;
        n_free      = r_free;
        n_req       = r_req;
        n_pool      = r_pool;
        n_o_valid   = r_o_valid && !o_rsp.ready;
        n_o_status  = r_o_status;
        n_o_addr    = r_o_addr;
        n_o_moved   = r_o_moved;
        n_o_copy    = r_o_copy;
        n_o_large   = r_o_large;
        n_o_free    = r_o_free;
        n_o_req     = r_o_req;
        wr_en       = 1'b0;
        wr_idx      = r_cur;
        wr_data     = '0;

        if (apb_wr && paddr[2] == ffa_pkg::REG_POOL) begin
            n_pool = pwdata[CW-1:0];
        end

        case (r_state)
            ST_INIT: begin
                wr_en   = 1'b1;
                wr_idx  = '0;
                n_hint  = '0;
                n_req   = '0;
                if (units < WW'(3)) begin
                    n_last = '0;
                    n_free = '0;
                end else begin
                    n_last = UW'(units - WW'(1));
                    n_free = u2b(units - WW'(1));
                end
                wr_data.nxt = n_last;
                n_state = r_from_op ? ST_DONE : ST_IDLE;
            end

            ST_IDLE: begin
                if (i_req.valid) begin
                    n_op        = i_req.op;
                    n_size      = i_req.size;
                    n_bsu       = bsu_in;
                    n_slack_new = slk_tmp[SW-1:0];
                    n_status    = 1'b0;
                    n_res_addr  = '0;
                    n_moved     = 1'b0;
                    n_move      = 1'b0;
                    n_best      = '0;
                    n_from_op   = 1'b1;
                    case (i_req.op)
                        ffa_pkg::OP_ALLOC,
                        ffa_pkg::OP_LARGEST: n_state = ST_AL_START;
                        ffa_pkg::OP_FREE,
                        ffa_pkg::OP_REALLOC: begin
                            if (addr_bad) begin
                                n_status = (i_req.op == ffa_pkg::OP_REALLOC);
                                n_state  = ST_DONE;
                            end else begin
                                n_t     = t_in;
                                n_cur   = '0;
                                n_state = ST_FIND;
                            end
                        end
                        ffa_pkg::OP_INIT: n_state = ST_INIT;
                        default: n_state = ST_DONE;
                    endcase
                end
            end

            // walk the chain from unit 0 to the target header
            ST_FIND: begin
                if (zx(r_cur) < r_t) begin
                    n_cur = nx_dec;
                end else if (zx(r_cur) == r_t && used_dec) begin
                    n_h = r_cur;
                    if (r_op == ffa_pkg::OP_FREE || r_size == '0) begin
                        n_state = ST_FREE_HDR;
                    end else begin
                        n_state = ST_RE_HDR;
                    end
                end else begin
                    n_status = (r_op == ffa_pkg::OP_REALLOC);
                    n_state  = ST_DONE;
                end
            end

            ST_FREE_HDR: begin
                n_req  = r_req - old_dec;
                n_free = r_free + u2b(capu_dec);
                if (r_cur < r_hint) begin
                    n_hint = r_cur;
                end
                n_cur   = nx_dec;
                n_state = ST_FREE_MRG;
            end

            ST_FREE_MRG: begin
                if (used_dec) begin
                    wr_en       = 1'b1;
                    wr_idx      = r_h;
                    wr_data.nxt = r_cur;
                    n_state     = ST_DONE;
                end else begin
                    n_cur = nx_dec;
                end
            end

            ST_RE_HDR: begin
                n_old  = old_dec;
                n_nx   = nx_dec;
                n_capu = capu_dec;
                n_cur  = nx_dec;
                if (bsu_w <= capu_dec) begin
                    n_spare    = capu_dec - bsu_w;
                    n_req      = r_req + r_size - old_dec;
                    n_res_addr = addr_of(r_h);
                    if (capu_dec == bsu_w) begin
                        wr_en         = 1'b1;
                        wr_idx        = r_h;
                        wr_data.nxt   = nx_dec;
                        wr_data.slack = r_slack_new;
                        wr_data.used  = 1'b1;
                        n_state       = ST_DONE;
                    end else begin
                        n_shrink = 1'b1;
                        n_state  = ST_RE_NX;
                    end
                end else begin
                    n_shrink = 1'b0;
                    n_state  = ST_RE_NX;
                end
            end

            // r_cur holds the block after the one being resized
            ST_RE_NX: begin
                if (r_shrink) begin
                    wr_en         = 1'b1;
                    wr_idx        = r_h;
                    wr_data.used  = 1'b1;
                    wr_data.slack = r_slack_new;
                    if (used_dec && r_spare < WW'(2)) begin
                        wr_data.nxt   = r_nx;
                        wr_data.slack = r_slack_new + SW'(8);
                        n_state       = ST_DONE;
                    end else begin
                        wr_data.nxt = nn_h;
                        n_nn        = nn_h;
                        n_nn_next   = used_dec ? r_nx : nx_dec;
                        n_free      = r_free + u2b(r_spare);
                        if (nn_h < r_hint) begin
                            n_hint = nn_h;
                        end
                        n_state = ST_WR_NN;
                    end
                end else if (used_dec) begin
                    n_move  = 1'b1;
                    n_state = ST_AL_START;
                end else begin
                    n_cur   = nx_dec;
                    n_state = ST_RE_MRG;
                end
            end

            // grow into the free run that follows
            ST_RE_MRG: begin
                if (used_dec) begin
                    wr_en = 1'b1;
                    if (cap_h >= bsu_w) begin
                        wr_idx        = r_h;
                        wr_data.used  = 1'b1;
                        wr_data.nxt   = (spare_h >= WW'(2)) ? nn_h : r_cur;
                        wr_data.slack = (spare_h == WW'(1)) ? r_slack_new + SW'(8)
                                                             : r_slack_new;
                        n_req  = r_req + r_size - r_old;
                        n_free = r_free + u2b(r_capu)
                               - u2b(bsu_w + {{(WW-1){1'b0}}, spare_h == WW'(1)});
                        if (r_nx == r_hint) begin
                            n_hint = (spare_h >= WW'(2)) ? nn_h : r_cur;
                        end
                        n_res_addr = addr_of(r_h);
                        if (spare_h >= WW'(2)) begin
                            n_nn      = nn_h;
                            n_nn_next = r_cur;
                            n_state   = ST_WR_NN;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end else begin
                        // merge stays, then look elsewhere
                        wr_idx      = r_nx;
                        wr_data.nxt = r_cur;
                        n_move      = 1'b1;
                        n_state     = ST_AL_START;
                    end
                end else begin
                    n_cur = nx_dec;
                end
            end

            ST_AL_START: begin
                n_cur   = (r_hint > r_last) ? r_last : r_hint;
                n_first = 1'b1;
                n_state = ST_AL_WALK;
            end

            ST_AL_WALK: begin
                if (r_cur == r_last) begin
                    if (r_first && r_op != ffa_pkg::OP_LARGEST) begin
                        n_hint = r_cur;
                    end
                    if (r_op != ffa_pkg::OP_LARGEST) begin
                        n_status   = 1'b1;
                        n_res_addr = '0;
                    end
                    n_state = ST_DONE;
                end else if (used_dec) begin
                    n_cur = nx_dec;
                end else begin
                    if (r_first && r_op != ffa_pkg::OP_LARGEST) begin
                        n_hint = r_cur;
                    end
                    n_first = 1'b0;
                    n_node  = r_cur;
                    n_cur   = nx_dec;
                    n_state = ST_AL_MRG;
                end
            end

            // r_node is free; r_cur walks the free run after it
            ST_AL_MRG: begin
                if (used_dec) begin
                    wr_en  = 1'b1;
                    wr_idx = r_node;
                    if (r_op != ffa_pkg::OP_LARGEST && cap_n >= bsu_w) begin
                        wr_data.used  = 1'b1;
                        wr_data.nxt   = (spare_n >= WW'(2)) ? nn_n : r_cur;
                        wr_data.slack = (spare_n == WW'(1)) ? r_slack_new + SW'(8)
                                                             : r_slack_new;
                        n_req  = r_req + r_size;
                        n_free = r_free
                               - u2b(bsu_w + {{(WW-1){1'b0}}, spare_n == WW'(1)});
                        if (r_node == r_hint) begin
                            n_hint = (spare_n >= WW'(2)) ? nn_n : r_cur;
                        end
                        n_res_addr = addr_of(r_node);
                        n_moved    = r_move;
                        if (spare_n >= WW'(2)) begin
                            n_nn      = nn_n;
                            n_nn_next = r_cur;
                            n_state   = ST_WR_NN;
                        end else if (r_move) begin
                            n_cur   = r_h;
                            n_state = ST_FREE_HDR;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end else begin
                        wr_data.nxt = r_cur;
                        if (r_op == ffa_pkg::OP_LARGEST && cap_n > r_best) begin
                            n_best = cap_n;
                        end
                        if (r_cur == r_last) begin
                            if (r_op != ffa_pkg::OP_LARGEST) begin
                                n_status   = 1'b1;
                                n_res_addr = '0;
                            end
                            n_state = ST_DONE;
                        end else begin
                            n_cur   = nx_dec;
                            n_state = ST_AL_WALK;
                        end
                    end
                end else begin
                    n_cur = nx_dec;
                end
            end

            ST_WR_NN: begin
                wr_en       = 1'b1;
                wr_idx      = r_nn;
                wr_data.nxt = r_nn_next;
                if (r_move) begin
                    n_cur   = r_h;
                    n_state = ST_FREE_HDR;
                end else begin
                    n_state = ST_DONE;
                end
            end

            ST_DONE: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_addr   = r_res_addr;
                    n_o_moved  = r_moved;
                    n_o_copy   = r_moved ? r_old : '0;
                    n_o_large  = u2b(r_best);
                    n_o_free   = n_free;
                    n_o_req    = n_req;
                    n_state    = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        r_q <= r_mem[n_cur];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_from_op <= 1'b0;
            r_pool    <= ffa_pkg::POOL_RESET;
            r_cur     <= '0;
            r_last    <= '0;
            r_hint    <= '0;
            r_free    <= '0;
            r_req     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_from_op <= n_from_op;
            r_pool    <= n_pool;
            r_cur     <= n_cur;
            r_last    <= n_last;
            r_hint    <= n_hint;
            r_free    <= n_free;
            r_req     <= n_req;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_size      <= n_size;
        r_bsu       <= n_bsu;
        r_slack_new <= n_slack_new;
        r_t         <= n_t;
        r_h         <= n_h;
        r_node      <= n_node;
        r_nx        <= n_nx;
        r_nn        <= n_nn;
        r_nn_next   <= n_nn_next;
        r_capu      <= n_capu;
        r_spare     <= n_spare;
        r_old       <= n_old;
        r_shrink    <= n_shrink;
        r_first     <= n_first;
        r_move      <= n_move;
        r_moved     <= n_moved;
        r_status    <= n_status;
        r_res_addr  <= n_res_addr;
        r_best      <= n_best;
        r_o_status  <= n_o_status;
        r_o_addr    <= n_o_addr;
        r_o_moved   <= n_o_moved;
        r_o_copy    <= n_o_copy;
        r_o_large   <= n_o_large;
        r_o_free    <= n_o_free;
        r_o_req     <= n_o_req;
    end

    a_hint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hint <= r_last)
        else $error("first-free hint beyond sentinel");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status |-> o_rsp.result_address == '0 && !o_rsp.moved)
        else $error("failed item carries an address or move");

    a_move_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.moved |-> !o_rsp.status && o_rsp.result_address != '0)
        else $error("move reported on a failed item");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("item taken while sequencer busy");

endmodule

`default_nettype wire
